[src/assert_macros.svh]
// Assertion macros for the additive marker effect score unit.
// Expects signals named clock and reset in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AMESU_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define AMESU_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/amesu_pkg.sv]
// Package for the additive marker effect score unit: widths, codes, beat types.
// No dependencies.
package amesu_pkg;

   localparam int MARKER_COUNT_DEFAULT = 4096;
   localparam int ALLELE_ROWS_DEFAULT  = 4;
   localparam int EFFECT_BITS_DEFAULT  = 16;

   localparam int MARKER_FIELD_BITS = 12;
   localparam int EFFECT_FIELD_BITS = 16;
   localparam int CODE_BITS         = 8;
   localparam int CODE_REGS         = 4;
   localparam int ROW_FIELD_BITS    = 2;
   localparam int USE_BITS          = 3;
   localparam int SCORE_BITS        = 32;
   localparam int ADD_BITS          = EFFECT_FIELD_BITS + 4;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 8;

   localparam int MID_DEPTH = 4;
   localparam int RSP_DEPTH = 4;

   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_SCORE = 1'b1;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_ALLELE_CODE_0  = 3'd0,
      CSR_ALLELE_CODE_1  = 3'd1,
      CSR_ALLELE_CODE_2  = 3'd2,
      CSR_ALLELE_CODE_3  = 3'd3,
      CSR_ALLELES_IN_USE = 3'd4
   } csr_index_type;

   localparam logic [CODE_BITS-1:0] ALLELE_CODE_RESET [CODE_REGS] =
      '{8'd65, 8'd84, 8'd67, 8'd71};

   typedef struct packed {
      logic signed [ADD_BITS-1:0] add;
      logic                       last;
      logic                       no_effects;
   } mid_entry_type;

   typedef struct packed {
      logic signed [SCORE_BITS-1:0] score;
      logic                         saturated;
      logic                         no_effects;
   } rsp_entry_type;

endpackage

[src/amesu_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module amesu_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                                        clock,
   input  logic                                        we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  waddr,
   input  logic [WIDTH-1:0]                            wdata,
   input  logic                                        re,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  raddr,
   output logic [WIDTH-1:0]                            rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[src/amesu_fifo.sv]
// Small synchronous FIFO with full and almost-full flags; DEPTH a power of two.
// No dependencies.
module amesu_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   output logic             full,
   output logic             afull,
   input  logic             pop,
   output logic [WIDTH-1:0] dout,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] data_ff [DEPTH];
   logic [PW-1:0]    wptr_ff, wptr_in;
   logic [PW-1:0]    rptr_ff, rptr_in;
   logic [PW:0]      level_ff, level_in;
   logic             do_push, do_pop;

   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wptr_in  = do_push ? wptr_ff + PW'(1) : wptr_ff;
      rptr_in  = do_pop ? rptr_ff + PW'(1) : rptr_ff;
      level_in = level_ff + (PW+1)'(do_push) - (PW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         level_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         level_ff <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         data_ff[wptr_ff] <= din;
      end
   end

   assign dout  = data_ff[rptr_ff];
   assign empty = (level_ff == '0);
   assign full  = (level_ff == (PW+1)'(DEPTH));
   assign afull = (level_ff >= (PW+1)'(DEPTH - 1));

endmodule

[src/amesu_front.sv]
// Front end: config registers, beat accept, allele compare, effect table lanes,
// per-marker contribution. Depends on amesu_pkg and amesu_ram.
module amesu_front #(
   parameter int MARKER_COUNT = amesu_pkg::MARKER_COUNT_DEFAULT,
   parameter int ALLELE_ROWS  = amesu_pkg::ALLELE_ROWS_DEFAULT,
   parameter int EFFECT_BITS  = amesu_pkg::EFFECT_BITS_DEFAULT
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        csr_we,
   input  logic [amesu_pkg::CSR_INDEX_BITS-1:0]        csr_index,
   input  logic [amesu_pkg::CSR_DATA_BITS-1:0]         csr_wdata,
   input  logic                                        req_push,
   output logic                                        req_full,
   input  logic                                        req_mode,
   input  logic [amesu_pkg::MARKER_FIELD_BITS-1:0]     req_marker_index,
   input  logic [amesu_pkg::ROW_FIELD_BITS-1:0]        req_allele_row,
   input  logic signed [amesu_pkg::EFFECT_FIELD_BITS-1:0] req_effect_value,
   input  logic [amesu_pkg::CODE_BITS-1:0]             req_allele_first,
   input  logic [amesu_pkg::CODE_BITS-1:0]             req_allele_second,
   input  logic                                        req_last_marker,
   input  logic                                        mid_afull,
   output logic                                        mid_push,
   output amesu_pkg::mid_entry_type                    mid_entry
);

   localparam int SW = (EFFECT_BITS < amesu_pkg::EFFECT_FIELD_BITS) ?
                       EFFECT_BITS : amesu_pkg::EFFECT_FIELD_BITS;
   localparam int MW = (MARKER_COUNT > 1) ? $clog2(MARKER_COUNT) : 1;
   localparam int XW = MW + amesu_pkg::MARKER_FIELD_BITS;

   logic [amesu_pkg::CODE_BITS-1:0] code_ff [amesu_pkg::CODE_REGS];
   logic [amesu_pkg::USE_BITS-1:0]  in_use_ff;
   logic [amesu_pkg::USE_BITS-1:0]  rows;

   logic          accept, in_range, is_score;
   logic [XW-1:0] marker_ext;
   logic [MW-1:0] addr;

   logic       va_ff, va_in;
   logic       last_ff, last_in;
   logic       noeff_ff, noeff_in;
   logic [1:0] cnt_ff [ALLELE_ROWS];
   logic [1:0] cnt_in [ALLELE_ROWS];
   logic [SW-1:0] rdata [ALLELE_ROWS];
   logic signed [amesu_pkg::ADD_BITS-1:0] add_sum;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < amesu_pkg::CODE_REGS; i++) begin
            code_ff[i] <= amesu_pkg::ALLELE_CODE_RESET[i];
         end
         in_use_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            amesu_pkg::CSR_ALLELE_CODE_0:  code_ff[0] <= csr_wdata;
            amesu_pkg::CSR_ALLELE_CODE_1:  code_ff[1] <= csr_wdata;
            amesu_pkg::CSR_ALLELE_CODE_2:  code_ff[2] <= csr_wdata;
            amesu_pkg::CSR_ALLELE_CODE_3:  code_ff[3] <= csr_wdata;
            amesu_pkg::CSR_ALLELES_IN_USE:
               in_use_ff <= csr_wdata[amesu_pkg::USE_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign rows = (in_use_ff > amesu_pkg::USE_BITS'(ALLELE_ROWS)) ?
                 amesu_pkg::USE_BITS'(ALLELE_ROWS) : in_use_ff;

   assign req_full   = mid_afull;
   assign accept     = req_push && !req_full;
   assign is_score   = (req_mode == amesu_pkg::MODE_SCORE);
   assign in_range   = (32'(req_marker_index) < 32'(MARKER_COUNT));
   assign marker_ext = XW'(req_marker_index);
   assign addr       = marker_ext[MW-1:0];

   always_comb begin
      va_in    = accept && is_score;
      last_in  = req_last_marker;
      noeff_in = (rows == '0);
      for (int r = 0; r < ALLELE_ROWS; r++) begin
         logic m1, m2, used;
         m1   = (req_allele_first == code_ff[r]);
         m2   = (req_allele_second == code_ff[r]);
         used = (amesu_pkg::USE_BITS'(r) < rows) && in_range;
         cnt_in[r] = used ? {m1 && m2, m1 ^ m2} : 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else begin
         va_ff <= va_in;
      end
   end

   always_ff @(posedge clock) begin
      if (va_in) begin
         last_ff  <= last_in;
         noeff_ff <= noeff_in;
         cnt_ff   <= cnt_in;
      end
   end

   for (genvar g = 0; g < ALLELE_ROWS; g++) begin : g_lane
      amesu_ram #(
         .WIDTH (SW),
         .DEPTH (MARKER_COUNT)
      ) u_ram (
         .clock (clock),
         .we    (accept && !is_score && in_range &&
                 (req_allele_row == amesu_pkg::ROW_FIELD_BITS'(g))),
         .waddr (addr),
         .wdata (req_effect_value[SW-1:0]),
         .re    (va_in),
         .raddr (addr),
         .rdata (rdata[g])
      );
   end

   always_comb begin
      add_sum = '0;
      for (int r = 0; r < ALLELE_ROWS; r++) begin
         logic signed [amesu_pkg::ADD_BITS-1:0] e;
         e = amesu_pkg::ADD_BITS'(signed'(rdata[r]));
         unique case (cnt_ff[r])
            2'd1:    add_sum = add_sum + e;
            2'd2:    add_sum = add_sum + (e <<< 1);
            default: add_sum = add_sum;
         endcase
      end
   end

   assign mid_push              = va_ff;
   assign mid_entry.add         = add_sum;
   assign mid_entry.last        = last_ff;
   assign mid_entry.no_effects  = noeff_ff;

endmodule

[src/amesu_back.sv]
// Back end: saturating accumulator, result beat on the last marker.
// Depends on amesu_pkg.
module amesu_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      mid_empty,
   input  amesu_pkg::mid_entry_type  mid_entry,
   output logic                      mid_pop,
   input  logic                      rsp_afull,
   output logic                      rsp_push,
   output amesu_pkg::rsp_entry_type  rsp_entry
);

   localparam int SB = amesu_pkg::SCORE_BITS;

   logic signed [SB-1:0] sum_ff, sum_in;
   logic                 clip_ff, clip_in;
   logic signed [SB:0]   sum_wide;
   logic signed [SB-1:0] sum_sat;
   logic                 ovf;

   assign mid_pop  = !mid_empty && (!mid_entry.last || !rsp_afull);
   assign sum_wide = (SB+1)'(sum_ff) + (SB+1)'(mid_entry.add);
   assign ovf      = (sum_wide[SB] != sum_wide[SB-1]);

   always_comb begin
      if (!ovf) begin
         sum_sat = sum_wide[SB-1:0];
      end else if (sum_wide[SB]) begin
         sum_sat = {1'b1, {(SB-1){1'b0}}};
      end else begin
         sum_sat = {1'b0, {(SB-1){1'b1}}};
      end
   end

   always_comb begin
      sum_in  = sum_ff;
      clip_in = clip_ff;
      if (mid_pop) begin
         if (mid_entry.last) begin
            sum_in  = '0;
            clip_in = 1'b0;
         end else begin
            sum_in  = sum_sat;
            clip_in = clip_ff || ovf;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff  <= '0;
         clip_ff <= 1'b0;
      end else begin
         sum_ff  <= sum_in;
         clip_ff <= clip_in;
      end
   end

   assign rsp_push             = mid_pop && mid_entry.last;
   assign rsp_entry.score      = mid_entry.no_effects ? '0 : sum_sat;
   assign rsp_entry.saturated  = !mid_entry.no_effects && (clip_ff || ovf);
   assign rsp_entry.no_effects = mid_entry.no_effects;

endmodule

[src/additive_marker_effect_score_unit.sv]
// Channel | ports                               | beat moves when
// req     | req_push/req_full + item fields      | req_push && !req_full
// rsp     | rsp_empty/rsp_pop + result fields    | rsp_pop && !rsp_empty
// csr     | csr_we, csr_index, csr_wdata         | csr_we
//
// One item per cycle sustained while req_full is low; a score beat passes the effect
// RAM read register and middle queue before accumulation. Load beats write the RAM lanes
// at accept. req_full follows the four-deep middle queue; a stalled rsp side
// backs up through it. Reset is synchronous; the effect table has no clearing pass.
//
// Top level: front end, middle queue, back end, result queue.
// Depends on amesu_pkg, amesu_front, amesu_back, amesu_fifo, assert_macros.svh.
`include "assert_macros.svh"

module additive_marker_effect_score_unit #(
   parameter int MARKER_COUNT = amesu_pkg::MARKER_COUNT_DEFAULT,
   parameter int ALLELE_ROWS  = amesu_pkg::ALLELE_ROWS_DEFAULT,
   parameter int EFFECT_BITS  = amesu_pkg::EFFECT_BITS_DEFAULT
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           csr_we,
   input  logic [amesu_pkg::CSR_INDEX_BITS-1:0]           csr_index,
   input  logic [amesu_pkg::CSR_DATA_BITS-1:0]            csr_wdata,
   input  logic                                           req_push,
   output logic                                           req_full,
   input  logic                                           req_mode,
   input  logic [amesu_pkg::MARKER_FIELD_BITS-1:0]        req_marker_index,
   input  logic [amesu_pkg::ROW_FIELD_BITS-1:0]           req_allele_row,
   input  logic signed [amesu_pkg::EFFECT_FIELD_BITS-1:0] req_effect_value,
   input  logic [amesu_pkg::CODE_BITS-1:0]                req_allele_first,
   input  logic [amesu_pkg::CODE_BITS-1:0]                req_allele_second,
   input  logic                                           req_last_marker,
   output logic                                           rsp_empty,
   input  logic                                           rsp_pop,
   output logic signed [amesu_pkg::SCORE_BITS-1:0]        rsp_score,
   output logic                                           rsp_saturated,
   output logic                                           rsp_no_effects
);

   localparam int MID_W = $bits(amesu_pkg::mid_entry_type);
   localparam int RSP_W = $bits(amesu_pkg::rsp_entry_type);

   logic                      mid_push, mid_pop, mid_full, mid_afull, mid_empty;
   amesu_pkg::mid_entry_type  mid_in, mid_out;
   logic                      rsp_push, rsp_full, rsp_afull;
   amesu_pkg::rsp_entry_type  rsp_in, rsp_out;

   amesu_front #(
      .MARKER_COUNT (MARKER_COUNT),
      .ALLELE_ROWS  (ALLELE_ROWS),
      .EFFECT_BITS  (EFFECT_BITS)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_mode          (req_mode),
      .req_marker_index  (req_marker_index),
      .req_allele_row    (req_allele_row),
      .req_effect_value  (req_effect_value),
      .req_allele_first  (req_allele_first),
      .req_allele_second (req_allele_second),
      .req_last_marker   (req_last_marker),
      .mid_afull         (mid_afull),
      .mid_push          (mid_push),
      .mid_entry         (mid_in)
   );

   amesu_fifo #(
      .WIDTH (MID_W),
      .DEPTH (amesu_pkg::MID_DEPTH)
   ) u_mid_fifo (
      .clock (clock),
      .reset (reset),
      .push  (mid_push),
      .din   (mid_in),
      .full  (mid_full),
      .afull (mid_afull),
      .pop   (mid_pop),
      .dout  (mid_out),
      .empty (mid_empty)
   );

   amesu_back u_back (
      .clock     (clock),
      .reset     (reset),
      .mid_empty (mid_empty),
      .mid_entry (mid_out),
      .mid_pop   (mid_pop),
      .rsp_afull (rsp_afull),
      .rsp_push  (rsp_push),
      .rsp_entry (rsp_in)
   );

   amesu_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (amesu_pkg::RSP_DEPTH)
   ) u_rsp_fifo (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .din   (rsp_in),
      .full  (rsp_full),
      .afull (rsp_afull),
      .pop   (rsp_pop),
      .dout  (rsp_out),
      .empty (rsp_empty)
   );

   assign rsp_score      = rsp_out.score;
   assign rsp_saturated  = rsp_out.saturated;
   assign rsp_no_effects = rsp_out.no_effects;

   `AMESU_ASSERT_IMPLY(a_mid_no_overflow, mid_push, !mid_full, "middle queue overflow")
   `AMESU_ASSERT_IMPLY(a_rsp_no_overflow, rsp_push, !rsp_full, "result queue overflow")
   `AMESU_ASSERT_NEXT(a_load_no_beat, req_push && !req_full && req_mode == amesu_pkg::MODE_LOAD, !mid_push, "load beat reached the back end")
   `AMESU_ASSERT_IMPLY(a_noeff_zero, !rsp_empty && rsp_no_effects, rsp_score == '0 && !rsp_saturated, "no-effects result not zero")

endmodule
